// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the predictor checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error(msg);

`endif

// ===== rtl/core/pbp_pkg.sv =====
// ----------------------------------------------------------------------------
// pbp_pkg
// Types and constants shared by the perceptron branch predictor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pbp_pkg;

   localparam int WEIGHT_W   = 9;
   localparam int PC_W       = 64;
   localparam int PC_SHIFT   = 2;
   localparam int GROUP_SIZE = 8;
   localparam int CFG_W      = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_BIT = 2;

   localparam logic [CFG_W-1:0] THRESHOLD_RESET = 8'd76;
   localparam logic [CFG_W-1:0] LIMIT_RESET     = 8'd255;

   typedef enum logic {
      REG_THRESHOLD = 1'b0,
      REG_LIMIT     = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [PC_W-1:0] branch_pc;
      logic            taken;
   } req_type;

   typedef struct packed {
      logic predicted_taken;
      logic was_correct;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_SUM   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic read;
      logic sum;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/pbp_csr.sv =====
// ----------------------------------------------------------------------------
// pbp_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pbp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [pbp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [pbp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output logic [pbp_pkg::CFG_W-1:0]         threshold,
   output logic [pbp_pkg::CFG_W-1:0]         limit
);
   import pbp_pkg::*;

   logic [CFG_W-1:0] threshold_ff, threshold_in;
   logic [CFG_W-1:0] limit_ff, limit_in;
   logic             write_en;
   csr_reg_type      reg_sel;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite && pready;
   assign reg_sel  = csr_reg_type'(paddr[CSR_IDX_BIT]);

   always_comb begin
      threshold_in = threshold_ff;
      limit_in     = limit_ff;
      prdata       = '0;
      unique case (reg_sel)
         REG_THRESHOLD: begin
            prdata = CSR_DATA_W'(threshold_ff);
            if (write_en) begin
               threshold_in = pwdata[CFG_W-1:0];
            end
         end
         REG_LIMIT: begin
            prdata = CSR_DATA_W'(limit_ff);
            if (write_en) begin
               limit_in = pwdata[CFG_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         limit_ff     <= LIMIT_RESET;
      end else begin
         threshold_ff <= threshold_in;
         limit_ff     <= limit_in;
      end
   end

   assign threshold = threshold_ff;
   assign limit     = limit_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbp_ctrl
// Sequencer for table clearing, row read, sum, and decide/write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pbp_pkg::status_type  status,
   output pbp_pkg::cmd_type     cmd
);
   import pbp_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign busy   = !((state_ff == ST_IDLE) || (state_ff == ST_DONE));
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = start ? ST_READ : ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.clear   = (state_ff == ST_CLEAR);
   assign cmd.capture = accept;
   assign cmd.read    = (state_ff == ST_READ);
   assign cmd.sum     = (state_ff == ST_SUM);
   assign cmd.done    = (state_ff == ST_DONE);

endmodule

`default_nettype wire

// ===== rtl/core/pbp_datapath.sv =====
// ----------------------------------------------------------------------------
// pbp_datapath
// Weight table, history register, registered adder tree and training logic.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_datapath #(
   parameter int TABLE_ENTRIES = 256,
   parameter int HISTORY_LEN   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pbp_pkg::cmd_type              cmd,
   output pbp_pkg::status_type           status,
   input  pbp_pkg::req_type              req_payload,
   input  logic [pbp_pkg::CFG_W-1:0]     threshold,
   input  logic [pbp_pkg::CFG_W-1:0]     limit,
   output logic                          rsp_valid,
   output pbp_pkg::rsp_type              rsp_payload
);
   import pbp_pkg::*;

   localparam int ROW_W      = $clog2(TABLE_ENTRIES);
   localparam int ROW_BITS   = HISTORY_LEN * WEIGHT_W;
   localparam int TERM_W     = WEIGHT_W + 1;
   localparam int NUM_GROUPS = (HISTORY_LEN + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_LEN    = NUM_GROUPS * GROUP_SIZE;
   localparam int GROUP_W    = TERM_W + $clog2(GROUP_SIZE);
   localparam int SUM_W      = GROUP_W + $clog2(NUM_GROUPS) + 1;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TABLE_ENTRIES - 1);

   logic [ROW_BITS-1:0] weight_mem [TABLE_ENTRIES];

   logic [ROW_W-1:0]                        clear_cnt_ff;
   logic [ROW_W-1:0]                        row_ff;
   logic                                    taken_ff;
   logic [HISTORY_LEN-1:0]                  hist_ff;
   logic [HISTORY_LEN-1:0][WEIGHT_W-1:0]    rdata_ff;
   logic signed [GROUP_W-1:0]               group_ff [NUM_GROUPS];
   logic                                    rsp_valid_ff;
   rsp_type                                 rsp_ff;

   logic signed [TERM_W-1:0]                term [PAD_LEN];
   logic signed [GROUP_W-1:0]               group_in [NUM_GROUPS];
   logic signed [SUM_W-1:0]                 y_sum;
   logic [SUM_W-1:0]                        y_mag;
   logic                                    pred;
   logic                                    train;
   logic signed [TERM_W-1:0]                nv [HISTORY_LEN];
   logic [TERM_W-1:0]                       nv_mag [HISTORY_LEN];
   logic [HISTORY_LEN-1:0][WEIGHT_W-1:0]    new_row;
   logic [ROW_W-1:0]                        row_in;
   logic                                    mem_we;
   logic [ROW_W-1:0]                        mem_waddr;
   logic [ROW_BITS-1:0]                     mem_wdata;

   assign row_in = req_payload.branch_pc[PC_SHIFT +: ROW_W] & LAST_ROW;
   assign status.clear_last = (clear_cnt_ff == LAST_ROW);

   always_comb begin
      for (int i = 0; i < PAD_LEN; i++) begin
         term[i] = '0;
      end
      for (int i = 0; i < HISTORY_LEN; i++) begin
         if ((i == 0) || hist_ff[i]) begin
            term[i] = TERM_W'($signed(rdata_ff[i]));
         end else begin
            term[i] = -TERM_W'($signed(rdata_ff[i]));
         end
      end
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            group_in[g] = group_in[g] + GROUP_W'(term[g * GROUP_SIZE + k]);
         end
      end
   end

   always_comb begin
      y_sum = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         y_sum = y_sum + SUM_W'(group_ff[g]);
      end
      y_mag = y_sum[SUM_W-1] ? SUM_W'(-y_sum) : SUM_W'(y_sum);
      pred  = !y_sum[SUM_W-1];
      train = (pred != taken_ff) || (y_mag <= SUM_W'(threshold));
   end

   always_comb begin
      for (int i = 0; i < HISTORY_LEN; i++) begin
         if ((i == 0) ? taken_ff : (taken_ff == hist_ff[i])) begin
            nv[i] = TERM_W'($signed(rdata_ff[i])) + TERM_W'(1);
         end else begin
            nv[i] = TERM_W'($signed(rdata_ff[i])) - TERM_W'(1);
         end
         nv_mag[i] = nv[i][TERM_W-1] ? TERM_W'(-nv[i]) : TERM_W'(nv[i]);
         if (train && (nv_mag[i] < TERM_W'(limit))) begin
            new_row[i] = nv[i][WEIGHT_W-1:0];
         end else begin
            new_row[i] = rdata_ff[i];
         end
      end
   end

   assign mem_we    = cmd.clear || cmd.done;
   assign mem_waddr = cmd.clear ? clear_cnt_ff : row_ff;
   assign mem_wdata = cmd.clear ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.read) begin
         rdata_ff <= weight_mem[row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff   <= row_in;
         taken_ff <= req_payload.taken;
      end
      if (cmd.sum) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            group_ff[g] <= group_in[g];
         end
      end
      if (cmd.done) begin
         rsp_ff.predicted_taken <= pred;
         rsp_ff.was_correct     <= (pred == taken_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         hist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clear_cnt_ff <= clear_cnt_ff + ROW_W'(1);
         end
         if (cmd.done) begin
            hist_ff <= {hist_ff[HISTORY_LEN-2:0], taken_ff};
         end
         rsp_valid_ff <= cmd.done;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/perceptron_branch_predictor_core.sv =====
// ----------------------------------------------------------------------------
// perceptron_branch_predictor_core
// Global-history perceptron predictor trained by resolved branches.
//
//   Channel   Direction  Signals                         Handshake
//   request   in         req_payload                     start & !busy
//   response  out        rsp_payload                     rsp_valid, one cycle
//   config    in/out     psel penable pwrite paddr ...   APB, pready high
//
// A branch passes three steps: weight row read, registered adder tree, then
// decide and write back. The next branch is taken in the write-back cycle.
// The result strobe is registered from the write-back step and rises after it.
// After reset the weight table is cleared one row a cycle, with busy high
// until the last row is written. The receiver has no way to stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module perceptron_branch_predictor_core #(
   parameter int TABLE_ENTRIES = 256,
   parameter int HISTORY_LEN   = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  pbp_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   output pbp_pkg::rsp_type                  rsp_payload,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pbp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [pbp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [pbp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import pbp_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic [CFG_W-1:0] threshold;
   logic [CFG_W-1:0] limit;

   pbp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .threshold (threshold),
      .limit     (limit)
   );

   pbp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   pbp_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .HISTORY_LEN   (HISTORY_LEN)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .threshold   (threshold),
      .limit       (limit),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== rtl/core/pbp_checker.sv =====
// ----------------------------------------------------------------------------
// pbp_checker
// Port-level checks of beat timing and result value for the predictor core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pbp_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  pbp_pkg::req_type   req_payload,
   input  logic               rsp_valid,
   input  pbp_pkg::rsp_type   rsp_payload
);
   import pbp_pkg::*;

   logic accept;

   assign accept = start && !busy;

   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "busy low after accept")

   `ASSERT_IMPLIES(a_result_latency, clock, reset, accept, ##4 rsp_valid, "result beat missing")

   `ASSERT_IMPLIES(a_result_value, clock, reset, accept, ##4 (rsp_payload.was_correct == (rsp_payload.predicted_taken == $past(req_payload.taken, 4))), "was_correct mismatch")

   `ASSERT_NEXT(a_single_beat, clock, reset, rsp_valid, !rsp_valid, "result beat repeated")

   `ASSERT_IMPLIES(a_clear_after_reset, clock, reset, $fell(reset), busy, "not busy while clearing")

endmodule

bind perceptron_branch_predictor_core pbp_checker u_pbp_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== tb/sv/perceptron_branch_predictor_core_test.sv =====
// ----------------------------------------------------------------------------
// perceptron_branch_predictor_core_test
// Drives resolved branches into the perceptron predictor and checks each
// prediction beat against a scoreboard that keeps its own weight rows, global
// history and register copies. Directed branches come first, then streams from
// a small pool of trained addresses mixed with random noise, under several
// threshold and limit settings written through the APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module perceptron_branch_predictor_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   import pbp_pkg::*;

   localparam int TABLE_ENTRIES  = 256;
   localparam int HISTORY_LEN    = 32;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int POOL_SIZE      = 8;

   class branch_scoreboard;
      logic signed [WEIGHT_W-1:0] weight_rows [TABLE_ENTRIES][HISTORY_LEN];
      logic [HISTORY_LEN-1:0] hist_bits;
      int unsigned train_threshold;
      int unsigned weight_limit;
      rsp_type outcome_queue[$];
      int errors;
      int branches;
      int mispredicts;
      int trainings;

      function void clear_state();
         foreach (weight_rows[r, i]) weight_rows[r][i] = '0;
         hist_bits = '0;
         train_threshold = THRESHOLD_RESET;
         weight_limit = LIMIT_RESET;
         outcome_queue.delete();
         errors = 0;
         branches = 0;
         mispredicts = 0;
         trainings = 0;
      endfunction

      function void set_reg(csr_reg_type which, logic [CFG_W-1:0] value);
         if (which == REG_THRESHOLD) begin
            train_threshold = value;
         end else begin
            weight_limit = value;
         end
      endfunction

      function int mag(int v);
         return (v < 0) ? -v : v;
      endfunction

      function void note_branch(req_type r);
         int row;
         int y;
         int step;
         int nv;
         logic pred;
         rsp_type want;
         row = int'((r.branch_pc >> PC_SHIFT) & 64'(TABLE_ENTRIES - 1));
         y = int'(weight_rows[row][0]);
         for (int i = 1; i < HISTORY_LEN; i++) begin
            y += hist_bits[i] ? int'(weight_rows[row][i]) : -int'(weight_rows[row][i]);
         end
         pred = (y >= 0);
         step = r.taken ? 1 : -1;
         if (pred != r.taken || mag(y) <= int'(train_threshold)) begin
            trainings++;
            nv = int'(weight_rows[row][0]) + step;
            if (mag(nv) < int'(weight_limit)) weight_rows[row][0] = WEIGHT_W'(nv);
            for (int i = 1; i < HISTORY_LEN; i++) begin
               nv = int'(weight_rows[row][i]) + (hist_bits[i] ? step : -step);
               if (mag(nv) < int'(weight_limit)) weight_rows[row][i] = WEIGHT_W'(nv);
            end
         end
         hist_bits = {hist_bits[HISTORY_LEN-2:0], r.taken};
         want.predicted_taken = pred;
         want.was_correct = (pred == r.taken);
         if (pred != r.taken) mispredicts++;
         branches++;
         outcome_queue.push_back(want);
      endfunction

      function void check_outcome(rsp_type got);
         rsp_type want;
         if (outcome_queue.size() == 0) begin
            $error("result beat with no branch pending");
            errors++;
            return;
         end
         want = outcome_queue.pop_front();
         if (got.predicted_taken !== want.predicted_taken) begin
            $error("predicted_taken: expected %0d, actual %0d",
                   want.predicted_taken, got.predicted_taken);
            errors++;
         end
         if (got.was_correct !== want.was_correct) begin
            $error("was_correct: expected %0d, actual %0d",
                   want.was_correct, got.was_correct);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   rsp_type               rsp_payload;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   branch_scoreboard sb = new;
   int idle_cycles = 0;
   int settings_used = 1;

   logic [PC_W-1:0] pool_pc [POOL_SIZE];
   int pool_mode [POOL_SIZE];
   int pool_period [POOL_SIZE];
   int pool_count [POOL_SIZE];
   logic last_taken = 1'b0;

   perceptron_branch_predictor_core #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .HISTORY_LEN  (HISTORY_LEN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_branch(req_payload);
         if (rsp_valid) sb.check_outcome(rsp_payload);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_branch(input req_type r);
      @(negedge clock);
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap(input int len);
      @(negedge clock);
      start <= 1'b0;
      req_payload <= {$urandom, $urandom, 1'($urandom)};
      repeat (len - 1) @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (sb.outcome_queue.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic write_reg(input csr_reg_type which, input logic [CFG_W-1:0] value);
      logic [CSR_ADDR_W-1:0] addr;
      addr = CSR_ADDR_W'(int'(which) << CSR_IDX_BIT);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= {24'($urandom_range(0, 32'hFF_FFFF)), value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.set_reg(which, value);
      @(negedge clock);
      psel <= 1'b1;
      paddr <= addr;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== CSR_DATA_W'(value)) begin
         $error("prdata: expected %0d, actual %0d", value, prdata);
         sb.errors++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic void refill_pool();
      for (int k = 0; k < POOL_SIZE; k++) begin
         pool_pc[k] = {$urandom, $urandom};
         pool_mode[k] = $urandom_range(0, 5);
         pool_period[k] = $urandom_range(2, 9);
         pool_count[k] = 0;
      end
   endfunction

   function automatic req_type make_branch();
      req_type r;
      int k;
      if ($urandom_range(0, 99) < 15) begin
         r.branch_pc = {$urandom, $urandom};
         r.taken = 1'($urandom);
      end else begin
         k = $urandom_range(0, POOL_SIZE - 1);
         r.branch_pc = pool_pc[k];
         case (pool_mode[k])
            0: r.taken = 1'b1;
            1: r.taken = 1'b0;
            2: r.taken = (pool_count[k] % pool_period[k]) != pool_period[k] - 1;
            3: r.taken = last_taken;
            4: r.taken = !last_taken;
            default: r.taken = 1'($urandom);
         endcase
         pool_count[k]++;
      end
      last_taken = r.taken;
      return r;
   endfunction

   task automatic stream(input int count);
      int burst;
      burst = $urandom_range(1, 24);
      for (int n = 0; n < count; n++) begin
         send_branch(make_branch());
         burst--;
         if (burst == 0) begin
            idle_gap(($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(1, 6));
            burst = $urandom_range(1, 24);
         end
      end
      drain();
   endtask

   task automatic configure(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] lim);
      drain();
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_LIMIT, lim);
      refill_pool();
      settings_used++;
   endtask

   initial begin
      req_type directed[$];
      sb.clear_state();
      refill_pool();
      directed.push_back('{branch_pc: 64'h0, taken: 1'b1});
      directed.push_back('{branch_pc: 64'h0, taken: 1'b0});
      directed.push_back('{branch_pc: '1, taken: 1'b1});
      directed.push_back('{branch_pc: '1, taken: 1'b0});
      directed.push_back('{branch_pc: 64'hFFFF_FFFF_FFFF_FFFC, taken: 1'b0});
      directed.push_back('{branch_pc: 64'h3, taken: 1'b1});
      directed.push_back('{branch_pc: 64'h3FC, taken: 1'b1});
      directed.push_back('{branch_pc: 64'h400, taken: 1'b0});
      directed.push_back('{branch_pc: 64'hAAAA_AAAA_AAAA_AAAA, taken: 1'b1});
      directed.push_back('{branch_pc: 64'h5555_5555_5555_5555, taken: 1'b0});
      for (int n = 0; n < 8; n++) begin
         directed.push_back('{branch_pc: 64'h8000_0000_0000_0100, taken: 1'b1});
      end
      for (int n = 0; n < 6; n++) begin
         directed.push_back('{branch_pc: 64'h200, taken: 1'(n % 2)});
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[n]) begin
         send_branch(directed[n]);
         if (n % 5 == 4) idle_gap($urandom_range(1, 4));
      end
      stream(180);

      configure(8'd0, 8'd1);
      stream(60);
      configure(8'd255, 8'd255);
      stream(150);
      configure(8'd0, 8'd255);
      stream(100);
      configure(8'd255, 8'd4);
      stream(100);
      for (int p = 0; p < 3; p++) begin
         configure(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)));
         stream(80);
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Covered %0d branches over %0d register settings: %0d mispredicted, %0d trained.",
               sb.branches, settings_used, sb.mispredicts, sb.trainings);
      if (sb.errors == 0 && sb.outcome_queue.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/pbp_pkg.sv
rtl/core/pbp_csr.sv
rtl/core/pbp_ctrl.sv
rtl/core/pbp_datapath.sv
rtl/core/perceptron_branch_predictor_core.sv
rtl/core/pbp_checker.sv
tb/sv/perceptron_branch_predictor_core_test.sv
